[src/crt_pkg.sv]
`timescale 1ns / 1ps

package crt_pkg;

   // Field widths of the request and response beats
   localparam int COORD_W     = 32;
   localparam int RADIUS_W    = 31;
   localparam int INDEX_W     = 14;
   localparam int SIDES_W     = 5;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 144;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   // Register map
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_SIDES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP_ENABLE = 1'b1;

   localparam logic [SIDES_W-1:0] SIDES_RESET = 5'd8;
   localparam logic [SIDES_W-1:0] MIN_SIDES   = 5'd3;

   // Q30 constants for the trig table
   localparam int                 Q30_SHIFT    = 30;
   localparam int                 SERIES_TERMS = 10;
   localparam logic signed [63:0] Q30_ONE      = 64'sh4000_0000;
   localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;

   // Series step divisors as reciprocals, ceil(2^64 / d), term 10 first
   localparam logic [127:0] RECIP_ONE = 128'd1 << 64;
   localparam logic [SERIES_TERMS:1][63:0] COS_RECIP = {
      64'((RECIP_ONE + 128'd379) / 128'd380), 64'((RECIP_ONE + 128'd305) / 128'd306),
      64'((RECIP_ONE + 128'd239) / 128'd240), 64'((RECIP_ONE + 128'd181) / 128'd182),
      64'((RECIP_ONE + 128'd131) / 128'd132), 64'((RECIP_ONE + 128'd89) / 128'd90),
      64'((RECIP_ONE + 128'd55) / 128'd56),   64'((RECIP_ONE + 128'd29) / 128'd30),
      64'((RECIP_ONE + 128'd11) / 128'd12),   64'((RECIP_ONE + 128'd1) / 128'd2)
   };
   localparam logic [SERIES_TERMS:1][63:0] SIN_RECIP = {
      64'((RECIP_ONE + 128'd419) / 128'd420), 64'((RECIP_ONE + 128'd341) / 128'd342),
      64'((RECIP_ONE + 128'd271) / 128'd272), 64'((RECIP_ONE + 128'd209) / 128'd210),
      64'((RECIP_ONE + 128'd155) / 128'd156), 64'((RECIP_ONE + 128'd109) / 128'd110),
      64'((RECIP_ONE + 128'd71) / 128'd72),   64'((RECIP_ONE + 128'd41) / 128'd42),
      64'((RECIP_ONE + 128'd19) / 128'd20),   64'((RECIP_ONE + 128'd5) / 128'd6)
   };

   typedef enum logic [1:0] {
      KIND_VERTEX   = 2'd0,
      KIND_CAP_TRI  = 2'd1,
      KIND_SIDE_TRI = 2'd2,
      KIND_REJECT   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_Z_ORDER = 2'd1,
      CAUSE_FULL    = 2'd2
   } cause_type;

   // Request beat, lowest field in the lowest bits
   typedef struct packed {
      logic [RADIUS_W-1:0]       ring_radius;
      logic signed [COORD_W-1:0] center_z;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_x;
   } req_data_type;

   // Response beat, lowest field in the lowest bits
   typedef struct packed {
      logic [3:0]                spare;
      cause_type                 reject_cause;
      logic [INDEX_W-1:0]        index_c;
      logic [INDEX_W-1:0]        index_b;
      logic [INDEX_W-1:0]        index_a;
      logic signed [COORD_W-1:0] vert_z;
      logic signed [COORD_W-1:0] vert_y;
      logic signed [COORD_W-1:0] vert_x;
   } rsp_data_type;

   // Taylor series of cos or sin for a first-quadrant angle in Q30.
   // Each step quotient stays below 2^34, so the reciprocal product is exact.
   function automatic logic signed [63:0] crt_series(input logic [63:0] x,
                                                     input logic sel_sin);
      logic [63:0]        x2;
      logic [63:0]        tc;
      logic [63:0]        ts;
      logic [127:0]       wide_c;
      logic [127:0]       wide_s;
      logic signed [63:0] c;
      logic signed [63:0] sn;
      int                 k;
      x2 = (x * x) >> Q30_SHIFT;
      c  = Q30_ONE;
      sn = x;
      tc = Q30_ONE;
      ts = x;
      for (k = 1; k <= SERIES_TERMS; k++) begin
         wide_c = {64'd0, (tc * x2) >> Q30_SHIFT} * {64'd0, COS_RECIP[k]};
         wide_s = {64'd0, (ts * x2) >> Q30_SHIFT} * {64'd0, SIN_RECIP[k]};
         tc = wide_c[127:64];
         ts = wide_s[127:64];
         if ((k % 2) == 1) begin
            c  = c - $signed(tc);
            sn = sn - $signed(ts);
         end else begin
            c  = c + $signed(tc);
            sn = sn + $signed(ts);
         end
      end
      return sel_sin ? sn : c;
   endfunction

   // Magnitude of a Q30 value rounded half away from zero, shifted right
   function automatic logic [63:0] crt_round_mag(input logic signed [63:0] v,
                                                 input int sh);
      logic [63:0] mag;
      mag = (v < 64'sd0) ? 64'(-v) : 64'(v);
      return (mag + (64'd1 << (sh - 1))) >> sh;
   endfunction

endpackage

[src/crt_trig_rom.sv]
`timescale 1ns / 1ps

module crt_trig_rom #(
   parameter int MAX_SIDES      = 16,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic [$clog2(MAX_SIDES)-1:0] sides_idx,   // sides minus one
   input  logic [$clog2(MAX_SIDES)-1:0] vtx_idx,
   output logic [TRIG_FRAC_BITS:0]      cos_mag,
   output logic                         cos_neg,
   output logic [TRIG_FRAC_BITS:0]      sin_mag,
   output logic                         sin_neg
);
   import crt_pkg::*;

   localparam int MW = TRIG_FRAC_BITS + 1;
   localparam int SH = Q30_SHIFT - TRIG_FRAC_BITS;

   logic [MW-1:0] cos_tab     [MAX_SIDES][MAX_SIDES];
   logic [MW-1:0] sin_tab     [MAX_SIDES][MAX_SIDES];
   logic          cos_neg_tab [MAX_SIDES][MAX_SIDES];
   logic          sin_neg_tab [MAX_SIDES][MAX_SIDES];

   // Fill the table at elaboration: angle 2*pi*i/s, reduced to a quadrant
   for (genvar gs = 0; gs < MAX_SIDES; gs++) begin : g_sides
      for (genvar gi = 0; gi < MAX_SIDES; gi++) begin : g_vtx
         if (gs >= 2 && gi <= gs) begin : g_entry
            localparam logic [63:0] SD = 64'(gs + 1);
            localparam logic [63:0] M  = 64'(4 * gi);
            localparam logic [1:0]  Q  = 2'((M / SD) % 64'd4);
            localparam logic [63:0] R  = M % SD;
            localparam logic [63:0] X  = (R * HALF_PI_Q30 + SD / 64'd2) / SD;
            localparam logic signed [63:0] C0 =
               (R == 64'd0) ? Q30_ONE : crt_series(X, 1'b0);
            localparam logic signed [63:0] S0 =
               (R == 64'd0) ? 64'sd0 : crt_series(X, 1'b1);
            localparam logic signed [63:0] COSV =
               (Q == 2'd0) ? C0 : (Q == 2'd1) ? -S0 : (Q == 2'd2) ? -C0 : S0;
            localparam logic signed [63:0] SINV =
               (Q == 2'd0) ? S0 : (Q == 2'd1) ? C0 : (Q == 2'd2) ? -S0 : -C0;

            assign cos_tab[gs][gi]     = MW'(crt_round_mag(COSV, SH));
            assign sin_tab[gs][gi]     = MW'(crt_round_mag(SINV, SH));
            assign cos_neg_tab[gs][gi] = (COSV < 64'sd0);
            assign sin_neg_tab[gs][gi] = (SINV < 64'sd0);
         end else begin : g_unused
            assign cos_tab[gs][gi]     = '0;
            assign sin_tab[gs][gi]     = '0;
            assign cos_neg_tab[gs][gi] = 1'b0;
            assign sin_neg_tab[gs][gi] = 1'b0;
         end
      end
   end

   // Look up one vertex
   assign cos_mag = cos_tab[sides_idx][vtx_idx];
   assign sin_mag = sin_tab[sides_idx][vtx_idx];
   assign cos_neg = cos_neg_tab[sides_idx][vtx_idx];
   assign sin_neg = sin_neg_tab[sides_idx][vtx_idx];

endmodule

[src/cylinder_ring_tessellator_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_*     in         center_x, center_y, center_z, ring_radius; tlast end_of_mesh
// rsp_*     out        vertex / triangle / reject record; tuser kind; tlast last of run
// csr_*     in         register write: index 0 ring_sides, index 1 cap_enable
//
// One ring with s sides gives s vertices, then s - 2 cap triangles if caps are on,
// then 2*s side triangles if it is not the first ring of the mesh; a rejected ring
// gives one reject beat. Each vertex uses the single shared multiplier twice (cos, then sin).
// Synchronous active-high reset clears ring count and last z, and sets the registers to 8 sides, caps off.
// Response stalls hold the sequencer; req_tready is high only between rings.
module cylinder_ring_tessellator_core #(
   parameter int MAX_SIDES      = 16,
   parameter int MAX_RINGS      = 1024,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // center_x[31:0], center_y[63:32], center_z[95:64], ring_radius[126:96]
   input  logic [crt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vert_x[31:0], vert_y[63:32], vert_z[95:64], index_a[109:96],
   // index_b[123:110], index_c[137:124], reject_cause[139:138]
   output logic [crt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind[1:0]
   output logic [crt_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [crt_pkg::CSR_DATA_W-1:0]     csr_data
);
   import crt_pkg::*;

   localparam int VCW = $clog2(MAX_SIDES + 1);
   localparam int SIW = $clog2(MAX_SIDES);
   localparam int RCW = $clog2(MAX_RINGS + 1);
   localparam int MW  = TRIG_FRAC_BITS + 1;
   localparam int PW  = RADIUS_W + MW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VTX_COS,
      ST_VTX_SIN,
      ST_CAP,
      ST_SIDE,
      ST_REJECT
   } state_type;

   state_type                 state_ff, state_in;
   logic [SIDES_W-1:0]        ring_sides_ff, ring_sides_in;
   logic                      cap_enable_ff, cap_enable_in;
   logic [RCW-1:0]            ring_count_ff, ring_count_in;
   logic signed [COORD_W-1:0] prev_z_ff, prev_z_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [COORD_W-1:0] cz_ff, cz_in;
   logic [RADIUS_W-1:0]       radius_ff, radius_in;
   logic [VCW-1:0]            sides_ff, sides_in;
   logic                      cap_ff, cap_in;
   logic                      has_prev_ff, has_prev_in;
   cause_type                 cause_ff, cause_in;
   logic [PW-1:0]             prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic signed [COORD_W-1:0] vx_ff, vx_in;
   logic [VCW-1:0]            vtx_ff, vtx_in;
   logic [INDEX_W-1:0]        base_ff, base_in;
   logic [INDEX_W-1:0]        prev_base_ff, prev_base_in;
   logic [INDEX_W-1:0]        lo_ff, lo_in;
   logic [INDEX_W-1:0]        hi_ff, hi_in;
   logic [INDEX_W-1:0]        capb_ff, capb_in;
   logic [VCW-1:0]            step_ff, step_in;
   logic                      odd_ff, odd_in;
   rsp_data_type              rsp_data_ff, rsp_data_in;
   kind_type                  rsp_kind_ff, rsp_kind_in;
   logic                      rsp_last_ff, rsp_last_in;

   req_data_type              req_beat;
   logic [VCW-1:0]            sides_clamp;
   logic [VCW-1:0]            sides_m1;
   cause_type                 cause;
   logic [RADIUS_W-1:0]       mul_a;
   logic [MW-1:0]             mul_b;
   logic [PW-1:0]             mul_p;
   logic [PW-1:0]             prod_round;
   logic [COORD_W-1:0]        scaled;
   logic signed [COORD_W-1:0] coord_base;
   logic signed [COORD_W-1:0] coord_sum;
   logic [MW-1:0]             cos_mag;
   logic [MW-1:0]             sin_mag;
   logic                      cos_neg;
   logic                      sin_neg;
   logic                      slot_free;
   logic                      emit;
   rsp_data_type              emit_data;
   kind_type                  emit_kind;
   logic                      emit_last;
   logic                      wrap;
   logic [INDEX_W-1:0]        lo_next;
   logic [INDEX_W-1:0]        hi_next;
   logic [INDEX_W-1:0]        base_new;

   assign req_beat   = req_data_type'(req_tdata[$bits(req_data_type)-1:0]);
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // Clamp the side count into the supported range
   always_comb begin
      if (ring_sides_ff < MIN_SIDES) begin
         sides_clamp = VCW'(MIN_SIDES);
      end else if (ring_sides_ff > SIDES_W'(MAX_SIDES)) begin
         sides_clamp = VCW'(MAX_SIDES);
      end else begin
         sides_clamp = VCW'(ring_sides_ff);
      end
   end

   // Check z order and ring capacity
   always_comb begin
      if (ring_count_ff != '0 && req_beat.center_z <= prev_z_ff) begin
         cause = CAUSE_Z_ORDER;
      end else if (ring_count_ff >= RCW'(MAX_RINGS)) begin
         cause = CAUSE_FULL;
      end else begin
         cause = CAUSE_NONE;
      end
   end

   assign sides_m1 = sides_ff - VCW'(1);

   crt_trig_rom #(
      .MAX_SIDES      (MAX_SIDES),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_trig_rom (
      .sides_idx (sides_m1[SIW-1:0]),
      .vtx_idx   (vtx_ff[SIW-1:0]),
      .cos_mag   (cos_mag),
      .cos_neg   (cos_neg),
      .sin_mag   (sin_mag),
      .sin_neg   (sin_neg)
   );

   // Shared multiplier and rounding adder
   assign mul_p      = PW'(mul_a) * PW'(mul_b);
   assign prod_round = prod_ff + (PW'(1) << (TRIG_FRAC_BITS - 1));
   assign scaled     = prod_round[TRIG_FRAC_BITS +: COORD_W];
   assign coord_sum  = neg_ff ? (coord_base - $signed(scaled))
                              : (coord_base + $signed(scaled));

   // Side triangle indices around the closing quad
   assign wrap     = (step_ff == sides_m1);
   assign lo_next  = wrap ? prev_base_ff : (lo_ff + INDEX_W'(1));
   assign hi_next  = wrap ? base_ff : (hi_ff + INDEX_W'(1));
   assign base_new = prod_ff[INDEX_W-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ring_sides_in = ring_sides_ff;
      cap_enable_in = cap_enable_ff;
      ring_count_in = ring_count_ff;
      prev_z_in     = prev_z_ff;
      pend_in       = pend_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      radius_in     = radius_ff;
      sides_in      = sides_ff;
      cap_in        = cap_ff;
      has_prev_in   = has_prev_ff;
      cause_in      = cause_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      vx_in         = vx_ff;
      vtx_in        = vtx_ff;
      base_in       = base_ff;
      prev_base_in  = prev_base_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      capb_in       = capb_ff;
      step_in       = step_ff;
      odd_in        = odd_ff;
      mul_a         = radius_ff;
      mul_b         = cos_mag;
      coord_base    = cx_ff;
      emit          = 1'b0;
      emit_data     = '0;
      emit_kind     = KIND_VERTEX;
      emit_last     = 1'b0;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_RING_SIDES: ring_sides_in = csr_data;
            CSR_CAP_ENABLE: cap_enable_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Ring base index: ring count times sides
            mul_a = RADIUS_W'(ring_count_ff);
            mul_b = MW'(sides_clamp);
            if (req_tvalid) begin
               cx_in       = req_beat.center_x;
               cy_in       = req_beat.center_y;
               cz_in       = req_beat.center_z;
               radius_in   = req_beat.ring_radius;
               sides_in    = sides_clamp;
               cap_in      = cap_enable_ff;
               has_prev_in = (ring_count_ff != '0);
               cause_in    = cause;
               prod_in     = mul_p;
               vtx_in      = '0;
               pend_in     = 1'b0;
               if (cause != CAUSE_NONE) begin
                  state_in = ST_REJECT;
               end else begin
                  ring_count_in = ring_count_ff + RCW'(1);
                  prev_z_in     = req_beat.center_z;
                  state_in      = ST_VTX_COS;
               end
               if (req_tlast) begin
                  ring_count_in = '0;
               end
            end
         end

         ST_VTX_COS: begin
            // Emit the pending vertex, start the cos product of the next
            mul_b      = cos_mag;
            coord_base = cy_ff;
            if (!pend_ff || slot_free) begin
               if (!pend_ff) begin
                  base_in      = base_new;
                  prev_base_in = base_new - INDEX_W'(sides_ff);
                  lo_in        = base_new - INDEX_W'(sides_ff);
                  hi_in        = base_new;
                  capb_in      = base_new + INDEX_W'(1);
               end else begin
                  emit             = 1'b1;
                  emit_kind        = KIND_VERTEX;
                  emit_data.vert_x = vx_ff;
                  emit_data.vert_y = coord_sum;
                  emit_data.vert_z = cz_ff;
               end
               if (vtx_ff == sides_ff) begin
                  pend_in = 1'b0;
                  step_in = '0;
                  odd_in  = 1'b0;
                  if (cap_ff) begin
                     state_in = ST_CAP;
                  end else if (has_prev_ff) begin
                     state_in = ST_SIDE;
                  end else begin
                     emit_last = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end else begin
                  prod_in  = mul_p;
                  neg_in   = cos_neg;
                  state_in = ST_VTX_SIN;
               end
            end
         end

         ST_VTX_SIN: begin
            // Finish x, start the sin product
            mul_b      = sin_mag;
            coord_base = cx_ff;
            vx_in      = coord_sum;
            prod_in    = mul_p;
            neg_in     = sin_neg;
            pend_in    = 1'b1;
            vtx_in     = vtx_ff + VCW'(1);
            state_in   = ST_VTX_COS;
         end

         ST_CAP: begin
            // Fan from the first vertex of the ring
            if (slot_free) begin
               emit              = 1'b1;
               emit_kind         = KIND_CAP_TRI;
               emit_data.index_a = base_ff;
               emit_data.index_b = capb_ff;
               emit_data.index_c = capb_ff + INDEX_W'(1);
               capb_in           = capb_ff + INDEX_W'(1);
               if (step_ff == sides_ff - VCW'(3)) begin
                  step_in = '0;
                  if (has_prev_ff) begin
                     state_in = ST_SIDE;
                  end else begin
                     emit_last = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end else begin
                  step_in = step_ff + VCW'(1);
               end
            end
         end

         ST_SIDE: begin
            // Two triangles per quad between the previous ring and this one
            if (slot_free) begin
               emit              = 1'b1;
               emit_kind         = KIND_SIDE_TRI;
               emit_data.index_a = lo_ff;
               if (!odd_ff) begin
                  emit_data.index_b = lo_next;
                  emit_data.index_c = hi_next;
                  odd_in            = 1'b1;
               end else begin
                  emit_data.index_b = hi_next;
                  emit_data.index_c = hi_ff;
                  odd_in            = 1'b0;
                  lo_in             = lo_ff + INDEX_W'(1);
                  hi_in             = hi_ff + INDEX_W'(1);
                  step_in           = step_ff + VCW'(1);
                  if (wrap) begin
                     emit_last = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end
            end
         end

         ST_REJECT: begin
            if (slot_free) begin
               emit                   = 1'b1;
               emit_kind              = KIND_REJECT;
               emit_data.reject_cause = cause_ff;
               emit_last              = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load or drain the response register
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_data_in  = emit_data;
         rsp_kind_in  = emit_kind;
         rsp_last_in  = emit_last;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ring_sides_ff <= SIDES_RESET;
         cap_enable_ff <= 1'b0;
         ring_count_ff <= '0;
         prev_z_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ring_sides_ff <= ring_sides_in;
         cap_enable_ff <= cap_enable_in;
         ring_count_ff <= ring_count_in;
         prev_z_ff     <= prev_z_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      radius_ff    <= radius_in;
      sides_ff     <= sides_in;
      cap_ff       <= cap_in;
      has_prev_ff  <= has_prev_in;
      cause_ff     <= cause_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      vx_ff        <= vx_in;
      vtx_ff       <= vtx_in;
      base_ff      <= base_in;
      prev_base_ff <= prev_base_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      capb_ff      <= capb_in;
      step_ff      <= step_in;
      odd_ff       <= odd_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

[verif/cylinder_ring_tessellator_core_tb.sv]
`timescale 1ns / 1ps

module cylinder_ring_tessellator_core_tb;
   import crt_pkg::*;

   localparam int MAX_SIDES      = 16;
   localparam int MAX_RINGS      = 1024;
   localparam int TRIG_FRAC_BITS = 16;
   localparam int TRIG_SHIFT     = 30 - TRIG_FRAC_BITS;
   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int DRAIN_TAIL     = 200;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int PRINT_CAP      = 200;

   // Quarter turn (pi/2) and one, both in Q30
   localparam logic [63:0]        QUARTER_TURN_Q30 = 64'd1686629713;
   localparam logic signed [63:0] UNIT_Q30         = 64'sd1073741824;

   typedef struct {
      kind_type    kind;
      logic [31:0] vert_x;
      logic [31:0] vert_y;
      logic [31:0] vert_z;
      logic [13:0] index_a;
      logic [13:0] index_b;
      logic [13:0] index_c;
      cause_type   cause;
      logic        last_of_run;
   } ring_beat_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Mesh state and registers as the block should hold them
   logic [4:0]  sides_reg  = SIDES_RESET;
   logic        caps_on    = 1'b0;
   int unsigned ring_total = 0;
   logic [31:0] last_z     = '0;

   ring_beat_type mesh_beats_due[$];
   int            error_count   = 0;
   int            beats_seen    = 0;
   int            cycle_count   = 0;
   int            req_gap_pct   = 0;
   int            rsp_stall_pct = 0;

   cylinder_ring_tessellator_core #(
      .MAX_SIDES      (MAX_SIDES),
      .MAX_RINGS      (MAX_RINGS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Stall the response side at the current rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_CAP) begin
         $display("%0t beat %0d %s: got %h want %h", $time, beats_seen, field, got, want);
      end
      error_count++;
   endtask

   // Round a Q30 value to TRIG_FRAC_BITS fraction bits, half away from zero
   function automatic logic signed [63:0] round_trig(input logic signed [63:0] v);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

   // Cosine and sine of 2*pi*i/s from a first-quadrant series and quadrant fold
   function automatic void angle_trig(input int unsigned i, input int unsigned s,
                                      output logic signed [63:0] co,
                                      output logic signed [63:0] si);
      logic [63:0]        m;
      logic [63:0]        quad;
      logic [63:0]        rem;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        tc;
      logic [63:0]        ts;
      logic signed [63:0] c;
      logic signed [63:0] sn;
      int                 k;
      m    = 64'(4 * i);
      quad = (m / 64'(s)) & 64'd3;
      rem  = m % 64'(s);
      x    = (rem * QUARTER_TURN_Q30 + 64'(s / 2)) / 64'(s);
      x2   = (x * x) >> 30;
      c    = UNIT_Q30;
      sn   = $signed(x);
      tc   = 64'(UNIT_Q30);
      ts   = x;
      for (k = 1; k <= 10; k++) begin
         tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
         ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            c  = c - $signed(tc);
            sn = sn - $signed(ts);
         end else begin
            c  = c + $signed(tc);
            sn = sn + $signed(ts);
         end
      end
      if (rem == 0) begin
         c  = UNIT_Q30;
         sn = 0;
      end
      case (quad[1:0])
         2'd0: begin
            co = c;
            si = sn;
         end
         2'd1: begin
            co = -sn;
            si = c;
         end
         2'd2: begin
            co = -c;
            si = -sn;
         end
         default: begin
            co = sn;
            si = -c;
         end
      endcase
      co = round_trig(co);
      si = round_trig(si);
   endfunction

   // Radius times a trig value, rounded back to Q16.16
   function automatic logic [31:0] scale_offset(input logic [30:0] radius,
                                                input logic signed [63:0] t);
      logic [63:0] mag;
      mag = 64'(radius) * (t[63] ? 64'(-t) : 64'(t));
      mag = (mag + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
      return t[63] ? 32'd0 - mag[31:0] : mag[31:0];
   endfunction

   function automatic ring_beat_type make_beat(input kind_type kind, input logic [31:0] vx,
                                               input logic [31:0] vy, input logic [31:0] vz,
                                               input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c, input cause_type cause);
      ring_beat_type beat;
      beat.kind        = kind;
      beat.vert_x      = vx;
      beat.vert_y      = vy;
      beat.vert_z      = vz;
      beat.index_a     = a[13:0];
      beat.index_b     = b[13:0];
      beat.index_c     = c[13:0];
      beat.cause       = cause;
      beat.last_of_run = 1'b0;
      return beat;
   endfunction

   // Append one beat behind those already due
   function automatic void queue_due(input ring_beat_type beat);
      mesh_beats_due = {mesh_beats_due, beat};
   endfunction

   // Work out every beat one ring causes and advance the mesh state
   function automatic void tessellate_ring(input logic [31:0] cx, input logic [31:0] cy,
                                           input logic [31:0] cz, input logic [30:0] radius,
                                           input logic eom);
      int unsigned        s;
      int unsigned        base;
      int unsigned        b;
      int unsigned        i;
      cause_type          cause;
      logic signed [63:0] co;
      logic signed [63:0] si;
      s = (sides_reg < MIN_SIDES) ? 3 : (sides_reg > MAX_SIDES) ? MAX_SIDES : sides_reg;
      cause = CAUSE_NONE;
      if (ring_total != 0 && $signed(cz) <= $signed(last_z)) begin
         cause = CAUSE_Z_ORDER;
      end else if (ring_total >= MAX_RINGS) begin
         cause = CAUSE_FULL;
      end
      if (cause != CAUSE_NONE) begin
         queue_due(make_beat(KIND_REJECT, 0, 0, 0, 0, 0, 0, cause));
      end else begin
         base = ring_total * s;
         for (i = 0; i < s; i++) begin
            angle_trig(i, s, co, si);
            queue_due(make_beat(KIND_VERTEX, cx + scale_offset(radius, co),
                                cy + scale_offset(radius, si), cz,
                                0, 0, 0, CAUSE_NONE));
         end
         if (caps_on) begin
            for (i = 1; i + 1 < s; i++) begin
               queue_due(make_beat(KIND_CAP_TRI, 0, 0, 0,
                                   base, base + i, base + i + 1, CAUSE_NONE));
            end
         end
         // Join to the previous ring, closing quad last
         if (ring_total != 0) begin
            b = base - s;
            for (i = 0; i + 1 < s; i++) begin
               queue_due(make_beat(KIND_SIDE_TRI, 0, 0, 0, b + i,
                                   b + i + 1, b + s + i + 1, CAUSE_NONE));
               queue_due(make_beat(KIND_SIDE_TRI, 0, 0, 0, b + i,
                                   b + s + i + 1, b + s + i, CAUSE_NONE));
            end
            queue_due(make_beat(KIND_SIDE_TRI, 0, 0, 0, b + s - 1, b, b + s,
                                CAUSE_NONE));
            queue_due(make_beat(KIND_SIDE_TRI, 0, 0, 0, b + s - 1, b + s,
                                b + 2 * s - 1, CAUSE_NONE));
         end
         ring_total = (ring_total + 1) & 32'h7FF;
         last_z     = cz;
      end
      mesh_beats_due[mesh_beats_due.size() - 1].last_of_run = 1'b1;
      if (eom) begin
         ring_total = 0;
      end
   endfunction

   // Compare each response beat with the oldest one due
   always @(posedge clock) begin
      rsp_data_type  got;
      ring_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata);
         if (mesh_beats_due.size() == 0) begin
            report_mismatch("beat with nothing due", rsp_tdata[63:0], 64'd0);
         end else begin
            want = mesh_beats_due.pop_front();
            if (rsp_tuser != want.kind) report_mismatch("kind", rsp_tuser, want.kind);
            if (got.vert_x != want.vert_x) report_mismatch("vert_x", got.vert_x, want.vert_x);
            if (got.vert_y != want.vert_y) report_mismatch("vert_y", got.vert_y, want.vert_y);
            if (got.vert_z != want.vert_z) report_mismatch("vert_z", got.vert_z, want.vert_z);
            if (got.index_a != want.index_a) begin
               report_mismatch("index_a", got.index_a, want.index_a);
            end
            if (got.index_b != want.index_b) begin
               report_mismatch("index_b", got.index_b, want.index_b);
            end
            if (got.index_c != want.index_c) begin
               report_mismatch("index_c", got.index_c, want.index_c);
            end
            if (got.reject_cause != want.cause) begin
               report_mismatch("reject_cause", got.reject_cause, want.cause);
            end
            if (rsp_tlast != want.last_of_run) begin
               report_mismatch("last_of_run", rsp_tlast, want.last_of_run);
            end
         end
         beats_seen++;
      end
   end

   task automatic wait_rings_drained();
      while (mesh_beats_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int gap_pct, input int stall_pct);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Register writes go in only once every due beat has come back
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_rings_drained();
      @(negedge clock);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_RING_SIDES) begin
         sides_reg = value;
      end else begin
         caps_on = value[0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Send one ring center; predict its beats on acceptance
   task automatic send_ring(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [30:0] radius,
                            input logic eom);
      req_data_type ring;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_gap_pct) @(negedge clock);
      ring.center_x    = cx;
      ring.center_y    = cy;
      ring.center_z    = cz;
      ring.ring_radius = radius;
      req_tdata  <= {1'b0, ring};
      req_tlast  <= eom;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tessellate_ring(cx, cy, cz, radius, eom);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [30:0] pick_radius();
      case ($urandom_range(0, 9))
         0: return 31'd0;
         1: return 31'd1;
         2: return 31'h7FFF_FFFF;
         3, 4, 5: return 31'($urandom_range(1, 32'h0010_0000));
         default: return 31'($urandom);
      endcase
   endfunction

   // Registers as they come out of reset: 8 sides, no caps
   task automatic test_reset_defaults();
      send_ring(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 31'h0001_0000, 1'b0);
      send_ring(32'h0000_8000, 32'h0003_0000, 32'h0002_0000, 31'h0002_8000, 1'b1);
   endtask

   // Coordinate and radius extremes, smallest and largest rings, caps on
   task automatic test_field_extremes();
      write_register(CSR_RING_SIDES, 5'd3);
      write_register(CSR_CAP_ENABLE, 5'd1);
      send_ring(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
      send_ring(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 31'd0, 1'b0);
      send_ring(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 31'd1, 1'b1);
      write_register(CSR_RING_SIDES, 5'd16);
      send_ring(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 1'b0);
      send_ring(32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 31'h0000_8000, 1'b1);
   endtask

   // Out-of-range side counts, changed from ring to ring within one mesh
   task automatic test_sides_clamp();
      write_register(CSR_CAP_ENABLE, 5'd0);
      write_register(CSR_RING_SIDES, 5'd0);
      send_ring(32'h0010_0000, 32'h0020_0000, 32'd10, 31'h0004_0000, 1'b0);
      write_register(CSR_RING_SIDES, 5'd31);
      send_ring(32'h0010_0000, 32'h0020_0000, 32'd20, 31'h0004_0000, 1'b0);
      write_register(CSR_RING_SIDES, 5'd2);
      send_ring(32'h0010_0000, 32'h0020_0000, 32'd30, 31'h0004_0000, 1'b1);
   endtask

   // Equal and falling z refused; end of mesh on a refused ring still restarts
   task automatic test_z_order();
      write_register(CSR_RING_SIDES, 5'd4);
      send_ring(32'h0000_1000, 32'h0000_2000, 32'd100, 31'h0001_0000, 1'b0);
      send_ring(32'h0000_1000, 32'h0000_2000, 32'd100, 31'h0001_0000, 1'b0);
      send_ring(32'h0000_1000, 32'h0000_2000, 32'd50, 31'h0001_0000, 1'b0);
      send_ring(32'h0000_1000, 32'h0000_2000, 32'd101, 31'h0001_0000, 1'b0);
      send_ring(32'h0000_1000, 32'h0000_2000, -32'sd5, 31'h0001_0000, 1'b1);
      send_ring(32'h0000_1000, 32'h0000_2000, -32'sd10, 31'h0001_0000, 1'b0);
      send_ring(32'h0000_1000, 32'h0000_2000, -32'sd9, 31'h0001_0000, 1'b1);
   endtask

   // Mostly well-formed meshes with random content, some stray and falling z
   task automatic test_random_meshes(input int ring_goal);
      int          sent;
      int          rings;
      int          n;
      int          pick;
      logic [31:0] z;
      logic [31:0] try_z;
      logic        eom;
      sent = 0;
      while (sent < ring_goal) begin
         if ($urandom_range(0, 3) == 0) begin
            write_register(CSR_RING_SIDES, ($urandom_range(0, 4) == 0) ?
                           5'($urandom_range(0, 31)) : 5'($urandom_range(3, 16)));
         end
         if ($urandom_range(0, 4) == 0) begin
            write_register(CSR_CAP_ENABLE, 5'($urandom_range(0, 1)));
         end
         rings = $urandom_range(1, 8);
         z     = $urandom;
         for (n = 0; n < rings; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               try_z = $urandom;
            end else if (pick < 14) begin
               try_z = z - $urandom_range(0, 1000);
            end else begin
               z     = z + ((pick < 20) ? 32'd1 : 32'($urandom_range(1, 32'h0010_0000)));
               try_z = z;
            end
            eom = (n == rings - 1) || ($urandom_range(0, 49) == 0);
            // hold off now and then until the block has emptied
            if ($urandom_range(0, 19) == 0) wait_rings_drained();
            send_ring($urandom, $urandom, try_z, pick_radius(), eom);
            sent++;
         end
      end
   endtask

   // Fill one mesh to capacity, then check the refusals around it
   task automatic test_capacity_full();
      logic [31:0] z;
      int          n;
      write_register(CSR_RING_SIDES, 5'd16);
      write_register(CSR_CAP_ENABLE, 5'd0);
      z = 32'h8000_0000;
      for (n = 0; n < MAX_RINGS; n++) begin
         z = z + $urandom_range(1, 4000);
         send_ring($urandom, $urandom, z, 31'($urandom_range(0, 32'h0004_0000)), 1'b0);
      end
      send_ring($urandom, $urandom, z + 32'd10, 31'h0001_0000, 1'b0);
      send_ring($urandom, $urandom, z, 31'h0001_0000, 1'b0);
      send_ring($urandom, $urandom, z + 32'd20, 31'h0001_0000, 1'b1);
      send_ring($urandom, $urandom, z - 32'd5, 31'h0001_0000, 1'b1);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(6, 73);
      test_reset_defaults();
      test_field_extremes();
      test_sides_clamp();
      test_z_order();
      test_random_meshes(150);

      set_idling(73, 6);
      test_random_meshes(150);

      set_idling(0, 0);
      test_random_meshes(150);
      test_capacity_full();

      // Drain, then watch for stray beats
      wait_rings_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[cylinder_ring_tessellator_core.f]
src/crt_pkg.sv
src/crt_trig_rom.sv
src/cylinder_ring_tessellator_core.sv
verif/cylinder_ring_tessellator_core_tb.sv
